@@ src/afdtd_pkg.sv @@
`timescale 1ns / 1ps
package afdtd_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int CELLS     = GRID_COLS * GRID_ROWS;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int FIELD_W   = 24;
  localparam int COEF_W    = 18;
  localparam int COORD_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = FIELD_W + 2;
  localparam int PROD_S_W  = FIELD_W + COEF_W;
  localparam int PROD_G_W  = DIFF_W + COEF_W;
  localparam int ACC_W     = PROD_G_W + 1;
  localparam int Q_W       = ACC_W - 16;

  localparam int FIELD_MAX = 8388607;
  localparam int FIELD_MIN = -8388608;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_DECAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ROW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COL      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_ROW      = 3'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PSWEEP,
    ST_PDRAIN,
    ST_VSWEEP,
    ST_VDRAIN,
    ST_PROBE,
    ST_RESULT
  } state_t;

  // Round Q13.32 to Q8.16 half up, then saturate to the field width.
  function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    logic signed [FIELD_W-1:0] res;
    biased = acc + ACC_W'(32768);
    q      = biased[ACC_W-1:16];
    if (q > $signed(Q_W'(FIELD_MAX))) begin
      res = FIELD_W'(FIELD_MAX);
    end else if (q < $signed(Q_W'(FIELD_MIN))) begin
      res = FIELD_W'(FIELD_MIN);
    end else begin
      res = q[FIELD_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/acoustic_fdtd_2d_stencil_top.sv @@
`timescale 1ns / 1ps
// Items are taken one at a time: a new item is accepted only in the idle state, after the
// previous result has been loaded into the output register. One cell per cycle through each
// sweep, set by the single write port of each field memory.
// Reset: synchronous, active high; registers take their reset values and a clearing
// pass zeroes all three fields before the first item is taken.
module acoustic_fdtd_2d_stencil_top
  import afdtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [FIELD_W-1:0]   s_tdata,   // [23:0] drive_sample
  input  logic                 s_tuser,   // [0] source_on
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [FIELD_W-1:0]   m_tdata    // [23:0] probe_pressure
);

  // Configuration registers.
  logic signed [COEF_W-1:0] pressure_decay, pressure_gain, velocity_decay, velocity_gain;
  logic [COORD_W-1:0] source_col, source_row, probe_col, probe_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_decay <= COEF_W'(65536);
      pressure_gain  <= '0;
      velocity_decay <= COEF_W'(65536);
      velocity_gain  <= '0;
      source_col     <= COORD_W'(32);
      source_row     <= COORD_W'(32);
      probe_col      <= COORD_W'(16);
      probe_row      <= COORD_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESSURE_DECAY: pressure_decay <= cfg_data;
        CFG_PRESSURE_GAIN:  pressure_gain  <= cfg_data;
        CFG_VELOCITY_DECAY: velocity_decay <= cfg_data;
        CFG_VELOCITY_GAIN:  velocity_gain  <= cfg_data;
        CFG_SOURCE_COL:     source_col     <= cfg_data[COORD_W-1:0];
        CFG_SOURCE_ROW:     source_row     <= cfg_data[COORD_W-1:0];
        CFG_PROBE_COL:      probe_col      <= cfg_data[COORD_W-1:0];
        CFG_PROBE_ROW:      probe_row      <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Source and probe placement. A source on an edge or outside the grid is dropped.
  logic              src_ok, probe_ok;
  logic [ADDR_W-1:0] src_addr, probe_addr;

  assign src_ok = (32'(source_col) >= 1) && (32'(source_col) <= GRID_COLS - 2) &&
                  (32'(source_row) >= 1) && (32'(source_row) <= GRID_ROWS - 2);
  assign probe_ok = (32'(probe_col) < GRID_COLS) && (32'(probe_row) < GRID_ROWS);
  assign src_addr   = ADDR_W'(32'(source_row) * GRID_COLS + 32'(source_col));
  assign probe_addr = ADDR_W'(32'(probe_row) * GRID_COLS + 32'(probe_col));

  // Sequencer.
  state_t            state, state_next;
  logic [ADDR_W-1:0] k;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              sweep_last;
  logic              pipe_busy;
  logic              in_accept;

  logic s1_v, s2_v, s3_v;

  assign sweep_last = (k == ADDR_W'(CELLS - 1));
  assign pipe_busy  = s1_v || s2_v || s3_v;
  assign in_accept  = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR:  if (sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_PSWEEP;
      end
      ST_PSWEEP: if (sweep_last) state_next = ST_PDRAIN;
      ST_PDRAIN: if (!pipe_busy) state_next = ST_VSWEEP;
      ST_VSWEEP: if (sweep_last) state_next = ST_VDRAIN;
      ST_VDRAIN: if (!pipe_busy) state_next = ST_PROBE;
      ST_PROBE:  state_next = ST_RESULT;
      ST_RESULT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      k     <= '0;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_PSWEEP || state == ST_VSWEEP) begin
        // Advance the raster scan; wrap at the end of each row and of the grid.
        if (sweep_last) begin
          k   <= '0;
          col <= '0;
          row <= '0;
        end else begin
          k <= k + 1'b1;
          if (col == COL_W'(GRID_COLS - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  // Read addresses. Pressure sweep reads P[k], VX[k], VX[k-1], VY[k], VY[k-COLS];
  // velocity sweep reads P[k+1], P[k+COLS], VX[k], VY[k]. P[k] for the velocity
  // sweep is the P[k+1] word of the previous cell. Wrapped addresses only feed
  // cells that are not written.
  logic [ADDR_W-1:0] p_addr_a, p_addr_b, vx_addr_b, vy_addr_b;

  always_comb begin
    if (state == ST_PROBE || state == ST_RESULT) begin
      p_addr_a = probe_addr;
    end else if (state == ST_VSWEEP) begin
      p_addr_a = k + 1'b1;
    end else begin
      p_addr_a = k;
    end
  end
  assign p_addr_b  = k + ADDR_W'(GRID_COLS);
  assign vx_addr_b = k - 1'b1;
  assign vy_addr_b = k - ADDR_W'(GRID_COLS);

  // Field memories.
  logic [FIELD_W-1:0] p_mem  [CELLS];
  logic [FIELD_W-1:0] vx_mem [CELLS];
  logic [FIELD_W-1:0] vy_mem [CELLS];

  logic signed [FIELD_W-1:0] p_rd_a, p_rd_b, vx_rd_a, vx_rd_b, vy_rd_a, vy_rd_b;

  logic               p_we, vx_we, vy_we;
  logic [ADDR_W-1:0]  p_wa, vx_wa, vy_wa;
  logic [FIELD_W-1:0] p_wd, vx_wd, vy_wd;

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rd_a <= p_mem[p_addr_a];
    p_rd_b <= p_mem[p_addr_b];
  end

  always_ff @(posedge clk) begin
    if (vx_we) vx_mem[vx_wa] <= vx_wd;
    vx_rd_a <= vx_mem[k];
    vx_rd_b <= vx_mem[vx_addr_b];
  end

  always_ff @(posedge clk) begin
    if (vy_we) vy_mem[vy_wa] <= vy_wd;
    vy_rd_a <= vy_mem[k];
    vy_rd_b <= vy_mem[vy_addr_b];
  end

  // Stage 1: read data arrives; form differences.
  logic              s1_vel;
  logic [ADDR_W-1:0] s1_k;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic signed [FIELD_W-1:0] p_prev, p_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_PSWEEP) || (state == ST_VSWEEP);
    end
    s1_vel <= (state == ST_VSWEEP);
    s1_k   <= k;
    s1_col <= col;
    s1_row <= row;
    // Hold P[k+1] so the next cell sees it as its own pressure.
    if (s1_v && s1_vel) p_prev <= p_rd_a;
  end

  // The first column is an edge, so its pressure is zero.
  assign p_here = (s1_col == '0) ? '0 : p_prev;

  logic signed [DIFF_W-1:0] diff0_c, diff1_c;
  logic signed [FIELD_W-1:0] self0_c, self1_c;
  logic we0_c, we1_c;

  always_comb begin
    if (s1_vel) begin
      diff0_c = DIFF_W'(p_rd_a) - DIFF_W'(p_here);
      diff1_c = DIFF_W'(p_rd_b) - DIFF_W'(p_here);
      self0_c = vx_rd_a;
      self1_c = vy_rd_a;
      we0_c   = (32'(s1_row) >= 1) && (32'(s1_row) <= GRID_ROWS - 2) &&
                (32'(s1_col) <= GRID_COLS - 2);
      we1_c   = (32'(s1_col) >= 1) && (32'(s1_col) <= GRID_COLS - 2) &&
                (32'(s1_row) <= GRID_ROWS - 2);
    end else begin
      diff0_c = DIFF_W'(vx_rd_a) - DIFF_W'(vx_rd_b) + DIFF_W'(vy_rd_a) - DIFF_W'(vy_rd_b);
      diff1_c = '0;
      self0_c = p_rd_a;
      self1_c = '0;
      we0_c   = (32'(s1_col) >= 1) && (32'(s1_col) <= GRID_COLS - 2) &&
                (32'(s1_row) >= 1) && (32'(s1_row) <= GRID_ROWS - 2);
      we1_c   = 1'b0;
    end
  end

  // Stage 2: registered operands; multiply.
  logic              s2_vel, s2_we0, s2_we1;
  logic [ADDR_W-1:0] s2_k;
  logic signed [DIFF_W-1:0]  s2_diff0, s2_diff1;
  logic signed [FIELD_W-1:0] s2_self0, s2_self1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_vel   <= s1_vel;
    s2_k     <= s1_k;
    s2_we0   <= s1_v && we0_c;
    s2_we1   <= s1_v && we1_c;
    s2_diff0 <= diff0_c;
    s2_diff1 <= diff1_c;
    s2_self0 <= self0_c;
    s2_self1 <= self1_c;
  end

  logic signed [COEF_W-1:0] coef_decay, coef_gain;
  assign coef_decay = s2_vel ? velocity_decay : pressure_decay;
  assign coef_gain  = s2_vel ? velocity_gain  : pressure_gain;

  // Stage 3: products; subtract, round, saturate and write back.
  logic              s3_vel, s3_we0, s3_we1;
  logic [ADDR_W-1:0] s3_k;
  logic signed [PROD_S_W-1:0] s3_ps0, s3_ps1;
  logic signed [PROD_G_W-1:0] s3_pg0, s3_pg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_vel <= s2_vel;
    s3_k   <= s2_k;
    s3_we0 <= s2_v && s2_we0;
    s3_we1 <= s2_v && s2_we1;
    s3_ps0 <= s2_self0 * coef_decay;
    s3_ps1 <= s2_self1 * coef_decay;
    s3_pg0 <= s2_diff0 * coef_gain;
    s3_pg1 <= s2_diff1 * coef_gain;
  end

  logic signed [FIELD_W-1:0] res0, res1;
  assign res0 = round_sat(ACC_W'(s3_ps0) - ACC_W'(s3_pg0));
  assign res1 = round_sat(ACC_W'(s3_ps1) - ACC_W'(s3_pg1));

  // Write port selection: clearing pass, source drive on accept, then sweep results.
  always_comb begin
    p_we  = 1'b0;
    p_wa  = s3_k;
    p_wd  = res0;
    vx_we = s3_v && s3_vel && s3_we0;
    vx_wa = s3_k;
    vx_wd = res0;
    vy_we = s3_v && s3_vel && s3_we1;
    vy_wa = s3_k;
    vy_wd = res1;
    if (state == ST_CLEAR) begin
      p_we  = 1'b1;
      p_wa  = k;
      p_wd  = '0;
      vx_we = 1'b1;
      vx_wa = k;
      vx_wd = '0;
      vy_we = 1'b1;
      vy_wa = k;
      vy_wd = '0;
    end else if (in_accept) begin
      p_we = s_tuser && src_ok;
      p_wa = src_addr;
      p_wd = s_tdata;
    end else begin
      p_we = s3_v && !s3_vel && s3_we0;
    end
  end

  // Output register: load the probe word once the previous result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
      m_tdata <= probe_ok ? p_rd_a : '0;
    end
  end

endmodule

@@ tb/tb_acoustic_fdtd_2d_stencil_top.sv @@
`timescale 1ns / 1ps
module tb_acoustic_fdtd_2d_stencil_top;
  import afdtd_pkg::*;

  localparam longint CYCLE_LIMIT = 5_000_000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [FIELD_W-1:0]   s_tdata;   // [23:0] drive_sample
  logic                 s_tuser;   // [0] source_on
  logic                 m_tvalid;
  logic                 m_tready;
  logic [FIELD_W-1:0]   m_tdata;   // [23:0] probe_pressure

  acoustic_fdtd_2d_stencil_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the grid and the register file.
  int                       pres[CELLS];
  int                       xvel[CELLS];
  int                       yvel[CELLS];
  logic signed [COEF_W-1:0] p_decay, p_gain, v_decay, v_gain;
  logic [COORD_W-1:0]       src_col, src_row, prb_col, prb_row;

  logic [FIELD_W-1:0] probe_due[$];
  int                 errors;
  longint             cycles;
  bit                 no_idle;   // hold both sides busy-free while set
  int                 out_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Round Q13.32 half up to Q8.16 and clamp to 24 bits.
  function automatic int round_clamp(longint acc);
    longint q;
    q = (acc + 64'sd32768) >>> 16;
    if (q > FIELD_MAX) return FIELD_MAX;
    if (q < FIELD_MIN) return FIELD_MIN;
    return int'(q);
  endfunction

  function automatic logic [FIELD_W-1:0] advance_grid(bit drive, logic [FIELD_W-1:0] sample);
    longint pd, pg, vd, vg, d;
    int     k;
    pd = longint'(p_decay);
    pg = longint'(p_gain);
    vd = longint'(v_decay);
    vg = longint'(v_gain);
    // Drive only interior cells; edges stay at zero.
    if (drive && src_col >= 1 && src_row >= 1 &&
        src_col <= GRID_COLS - 2 && src_row <= GRID_ROWS - 2)
      pres[src_row * GRID_COLS + src_col] = int'($signed(sample));
    for (int r = 1; r <= GRID_ROWS - 2; r++)
      for (int c = 1; c <= GRID_COLS - 2; c++) begin
        k = r * GRID_COLS + c;
        d = longint'(xvel[k]) - xvel[k-1] + longint'(yvel[k]) - yvel[k-GRID_COLS];
        pres[k] = round_clamp(pd * pres[k] - pg * d);
      end
    for (int r = 1; r <= GRID_ROWS - 2; r++)
      for (int c = 0; c <= GRID_COLS - 2; c++) begin
        k = r * GRID_COLS + c;
        d = longint'(pres[k+1]) - pres[k];
        xvel[k] = round_clamp(vd * xvel[k] - vg * d);
      end
    for (int r = 0; r <= GRID_ROWS - 2; r++)
      for (int c = 1; c <= GRID_COLS - 2; c++) begin
        k = r * GRID_COLS + c;
        d = longint'(pres[k+GRID_COLS]) - pres[k];
        yvel[k] = round_clamp(vd * yvel[k] - vg * d);
      end
    // A probe on a 6-bit coordinate always lands inside the 64x64 grid.
    return FIELD_W'(pres[prb_row * GRID_COLS + prb_col]);
  endfunction

  // Write one register; the block must be idle. Drop the enable before the next write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COEF_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PRESSURE_DECAY: p_decay = COEF_W'(value);
      CFG_PRESSURE_GAIN:  p_gain  = COEF_W'(value);
      CFG_VELOCITY_DECAY: v_decay = COEF_W'(value);
      CFG_VELOCITY_GAIN:  v_gain  = COEF_W'(value);
      CFG_SOURCE_COL:     src_col = COORD_W'(value);
      CFG_SOURCE_ROW:     src_row = COORD_W'(value);
      CFG_PROBE_COL:      prb_col = COORD_W'(value);
      default:            prb_row = COORD_W'(value);
    endcase
  endtask

  task automatic send_tick(bit drive, logic [FIELD_W-1:0] sample);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= drive;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    probe_due.push_back(advance_grid(drive, sample));
  endtask

  // Drop valid and wait for every pending result before touching registers.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (probe_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_coefs(int pd, int pg, int vd, int vg);
    write_reg(CFG_PRESSURE_DECAY, pd);
    write_reg(CFG_PRESSURE_GAIN, pg);
    write_reg(CFG_VELOCITY_DECAY, vd);
    write_reg(CFG_VELOCITY_GAIN, vg);
  endtask

  task automatic write_points(int sc, int sr, int pc, int pr);
    write_reg(CFG_SOURCE_COL, sc);
    write_reg(CFG_SOURCE_ROW, sr);
    write_reg(CFG_PROBE_COL, pc);
    write_reg(CFG_PROBE_ROW, pr);
  endtask

  // Reset values: gains are zero, so only the driven cell moves.
  task automatic test_reset_values;
    send_tick(1'b1, 24'h7FFFFF);
    send_tick(1'b0, 24'h000000);
    drain();
    write_reg(CFG_PROBE_COL, 32);
    send_tick(1'b1, 24'h800000);
    send_tick(1'b0, 24'h123456);
    drain();
  endtask

  // Field and coefficient extremes, edge sources and edge probes.
  task automatic test_extremes;
    no_idle = 1'b1;
    write_coefs(32768, 32768, 65536, 32768);
    write_points(5, 5, 6, 5);
    send_tick(1'b1, 24'h7FFFFF);
    send_tick(1'b1, 24'h800000);
    send_tick(1'b0, 24'h000001);
    send_tick(1'b1, 24'hFFFFFF);
    drain();
    no_idle = 1'b0;
    write_coefs(-131072, 131071, 131071, -131072);
    write_points(5, 5, 5, 5);
    send_tick(1'b1, 24'h7FFFFF);
    send_tick(1'b0, 24'h000000);
    send_tick(1'b1, 24'h800000);
    drain();
    // Source on an edge is ignored; probe on an edge reads zero.
    write_coefs(65536, 65536, 65536, 65536);
    write_points(0, 10, 1, 10);
    send_tick(1'b1, 24'h400000);
    drain();
    write_reg(CFG_PROBE_COL, 63);
    send_tick(1'b1, 24'h400000);
    drain();
    write_points(63, 63, 62, 62);
    send_tick(1'b1, 24'h7FFFFF);
    drain();
    write_points(10, 0, 10, 0);
    send_tick(1'b1, 24'h7FFFFF);
    drain();
    write_points(62, 62, 62, 62);
    send_tick(1'b1, 24'h654321);
    send_tick(1'b0, 24'h000000);
    drain();
  endtask

  task automatic test_random_ticks;
    int sc, sr;
    for (int phase = 0; phase < 5; phase++) begin
      no_idle = (phase == 2);
      write_coefs($urandom_range(0, 262143) - 131072, $urandom_range(0, 131071) - 65536,
                  $urandom_range(32768, 70000), $urandom_range(0, 131071) - 65536);
      sc = $urandom_range(0, 63);
      sr = $urandom_range(0, 63);
      // Keep the probe close to the source most of the time so it sees the wave.
      if ($urandom_range(0, 3) != 0)
        write_points(sc, sr, (sc + $urandom_range(0, 2)) % 64, (sr + $urandom_range(0, 2)) % 64);
      else
        write_points(sc, sr, $urandom_range(0, 63), $urandom_range(0, 63));
      for (int i = 0; i < 20; i++)
        send_tick($urandom_range(0, 3) != 0, FIELD_W'($urandom));
      drain();
    end
  endtask

  // Result side: random stall per item, compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      out_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      if (probe_due.size() == 0) begin
        $error("probe_pressure: unexpected result %h", m_tdata);
        errors++;
      end else begin
        if (m_tdata !== probe_due[0]) begin
          $error("probe_pressure: expected %h actual %h", probe_due[0], m_tdata);
          errors++;
        end
        void'(probe_due.pop_front());
      end
      out_stall <= no_idle ? 0 : $urandom_range(0, 13);
      m_tready  <= no_idle;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    errors    = 0;
    cycles    = 0;
    no_idle   = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    foreach (pres[i]) begin
      pres[i] = 0;
      xvel[i] = 0;
      yvel[i] = 0;
    end
    p_decay = 18'sd65536;
    p_gain  = '0;
    v_decay = 18'sd65536;
    v_gain  = '0;
    src_col = 6'd32;
    src_row = 6'd32;
    prb_col = 6'd16;
    prb_row = 6'd32;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_random_ticks();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/afdtd_pkg.sv
src/acoustic_fdtd_2d_stencil_top.sv
tb/tb_acoustic_fdtd_2d_stencil_top.sv
